[rtl/bsfe_pkg.sv]
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared constants and controller/datapath interface types for the board
// sparse feature extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsfe_pkg;

    // field widths
    localparam int unsigned SQ_W       = 64;
    localparam int unsigned NIB_W      = 128;
    localparam int unsigned SQ_IDX_W   = 6;
    localparam int unsigned ENTRY_W    = 12;
    localparam int unsigned FEAT_W     = 10;
    localparam int unsigned FNUM_W     = 18;
    localparam int unsigned SCORE_W    = 16;
    localparam int unsigned RES_W      = 2;
    localparam int unsigned BATCH_W    = 13;

    // batch limits
    localparam logic [BATCH_W-1:0] MAX_BATCH   = 13'd4096;
    localparam logic [BATCH_W-1:0] BATCH_RESET = 13'd4096;

    // feature index offset for black pieces
    localparam logic [FEAT_W-1:0]  BLACK_OFFSET = 10'd384;

    // game result codes
    localparam logic [RES_W-1:0]   RES_WIN     = 2'd2;
    localparam logic [RES_W-1:0]   RES_INVALID = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new record
        logic emit;   // produce the next feature into the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;   // the feature under work is the final one of the record
    } t_sts;

endpackage

[rtl/bsfe_ctrl.sv]
// ----------------------------------------------------------------------------
// bsfe_ctrl
// Control state machine: record acceptance, per-feature stepping and the
// output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfe_ctrl
    import bsfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    // output register can take a new result
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    // a result is never overwritten while it waits for the consumer
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while stalled");

    // an accepted record always starts the feature scan
    a_load_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RUN && !o_in_ready))
        else $error("record accepted without starting scan");

    // the final feature releases the input side in the next cycle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.last) |=> (o_in_ready && o_out_valid))
        else $error("input side not released after final feature");
`endif

endmodule

[rtl/bsfe_datapath.sv]
// ----------------------------------------------------------------------------
// bsfe_datapath
// Record registers, lowest-square scan, feature index build, batch counters
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfe_datapath
    import bsfe_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_cfg_we,
    input  logic [BATCH_W-1:0]        i_cfg_wdata,
    input  logic [SQ_W-1:0]           i_occupancy,
    input  logic [SQ_W-1:0]           i_pieces_low,
    input  logic [SQ_W-1:0]           i_pieces_high,
    input  logic                      i_white_to_move,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [RES_W-1:0]          i_game_result,
    output logic [ENTRY_W-1:0]        o_entry_index,
    output logic [FEAT_W-1:0]         o_feature_index,
    output logic                      o_feature_valid,
    output logic [FNUM_W-1:0]         o_feature_number,
    output logic                      o_side_white,
    output logic signed [SCORE_W-1:0] o_side_score,
    output logic [RES_W-1:0]          o_result_halves,
    output logic                      o_last_of_entry,
    output logic                      o_last_of_batch
);

    // configuration and batch counters
    logic [BATCH_W-1:0]        r_batch_len;
    logic [ENTRY_W-1:0]        r_entry_cnt;
    logic [FNUM_W-1:0]         r_feat_cnt;

    // record under work
    logic [SQ_W-1:0]           r_squares;
    logic [NIB_W-1:0]          r_nibbles;
    logic                      r_white;
    logic signed [SCORE_W-1:0] r_score;
    logic [RES_W-1:0]          r_halves;
    logic                      r_batch_end;

    // output register
    logic [ENTRY_W-1:0]        r_out_entry;
    logic [FEAT_W-1:0]         r_out_feat;
    logic                      r_out_fvalid;
    logic [FNUM_W-1:0]         r_out_fnum;
    logic                      r_out_white;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [RES_W-1:0]          r_out_halves;
    logic                      r_out_last_e;
    logic                      r_out_last_b;

    logic [BATCH_W-1:0]        w_eff_batch;
    logic [BATCH_W-1:0]        w_entry_inc;
    logic                      w_batch_end;
    logic [SQ_IDX_W-1:0]       w_sq;
    logic [SQ_W-1:0]           w_sq_next;
    logic                      w_empty;
    logic [3:0]                w_nib;
    logic [FEAT_W-1:0]         w_feat;
    logic [RES_W-1:0]          w_halves_in;

    // effective batch size: zero acts as one, clamp at the maximum
    always_comb begin
        w_eff_batch = r_batch_len;
        if (r_batch_len == '0) begin
            w_eff_batch = {{(BATCH_W-1){1'b0}}, 1'b1};
        end else if (r_batch_len > MAX_BATCH) begin
            w_eff_batch = MAX_BATCH;
        end
    end

    assign w_entry_inc = {1'b0, r_entry_cnt} + {{(BATCH_W-1){1'b0}}, 1'b1};
    assign w_batch_end = (w_entry_inc >= w_eff_batch);

    // result code three saturates to a win
    assign w_halves_in = (i_game_result == RES_INVALID) ? RES_WIN : i_game_result;

    // lowest occupied square
    always_comb begin
        w_sq = '0;
        for (int i = SQ_W - 1; i >= 0; i--) begin
            if (r_squares[i]) begin
                w_sq = SQ_IDX_W'(i);
            end
        end
    end

    assign w_sq_next = r_squares & (r_squares - {{(SQ_W-1){1'b0}}, 1'b1});
    assign w_empty   = (r_squares == '0);
    assign o_sts.last = (w_sq_next == '0);

    // feature index from the next piece nibble
    assign w_nib  = r_nibbles[3:0];
    assign w_feat = (w_nib[0] ? '0 : BLACK_OFFSET) + {1'b0, w_nib[3:1], w_sq};

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_len <= BATCH_RESET;
        end else if (i_cfg_we) begin
            r_batch_len <= i_cfg_wdata;
        end
    end

    // record capture and scan advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_squares <= '0;
            r_nibbles <= '0;
        end else if (i_cmd.load) begin
            r_squares <= i_occupancy;
            r_nibbles <= {i_pieces_high, i_pieces_low};
        end else if (i_cmd.emit) begin
            r_squares <= w_sq_next;
            r_nibbles <= {4'b0000, r_nibbles[NIB_W-1:4]};
        end
    end

    // per-record side data
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_white     <= i_white_to_move;
            r_score     <= i_score;
            r_halves    <= w_halves_in;
            r_batch_end <= w_batch_end;
        end
    end

    // batch counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_cnt <= '0;
            r_feat_cnt  <= '0;
        end else if (i_cmd.emit) begin
            if (o_sts.last && r_batch_end) begin
                r_entry_cnt <= '0;
                r_feat_cnt  <= '0;
            end else begin
                if (o_sts.last) begin
                    r_entry_cnt <= r_entry_cnt + 1'b1;
                end
                if (!w_empty) begin
                    r_feat_cnt <= r_feat_cnt + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_entry  <= r_entry_cnt;
            r_out_feat   <= w_empty ? '0 : w_feat;
            r_out_fvalid <= !w_empty;
            r_out_fnum   <= r_feat_cnt;
            r_out_white  <= r_white;
            r_out_score  <= r_score;
            r_out_halves <= r_halves;
            r_out_last_e <= o_sts.last;
            r_out_last_b <= o_sts.last && r_batch_end;
        end
    end

    assign o_entry_index    = r_out_entry;
    assign o_feature_index  = r_out_feat;
    assign o_feature_valid  = r_out_fvalid;
    assign o_feature_number = r_out_fnum;
    assign o_side_white     = r_out_white;
    assign o_side_score     = r_out_score;
    assign o_result_halves  = r_out_halves;
    assign o_last_of_entry  = r_out_last_e;
    assign o_last_of_batch  = r_out_last_b;

`ifndef ASSERT_OFF
    // the scan never starts on a record with leftover squares
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_squares == '0))
        else $error("new record loaded over unfinished scan");

    // an empty-board result ends its record
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && w_empty) |=> (!r_out_fvalid && r_out_last_e))
        else $error("empty board result not marked last");

    // batch end closes the entry and restarts both counters
    a_batch_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_sts.last && r_batch_end) |=>
            (r_entry_cnt == '0 && r_feat_cnt == '0 && r_out_last_e))
        else $error("counters not restarted at batch end");
`endif

endmodule

[rtl/board_sparse_feature_extractor_top.sv]
// ----------------------------------------------------------------------------
// board_sparse_feature_extractor_top
// Converts packed position records into sparse feature indices (0 to 895).
// ----------------------------------------------------------------------------
// A record is taken when the block is idle, then one feature per occupied
// square leaves at one per cycle while the output register is free (lowest
// square first), or a single result with feature_valid low for an empty
// board. The scan is serial over the occupancy mask and visits the occupied
// squares one at a time. The next record is taken in the cycle after the final
// feature leaves the scan, even while that feature still waits in the output
// register.
// The batch length register may be written only while the block is idle.
`timescale 1ns / 1ps

module board_sparse_feature_extractor_top
    import bsfe_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [BATCH_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [SQ_W-1:0]           i_occupancy,
    input  logic [SQ_W-1:0]           i_pieces_low,
    input  logic [SQ_W-1:0]           i_pieces_high,
    input  logic                      i_white_to_move,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [RES_W-1:0]          i_game_result,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ENTRY_W-1:0]        o_entry_index,
    output logic [FEAT_W-1:0]         o_feature_index,
    output logic                      o_feature_valid,
    output logic [FNUM_W-1:0]         o_feature_number,
    output logic                      o_side_white,
    output logic signed [SCORE_W-1:0] o_side_score,
    output logic [RES_W-1:0]          o_result_halves,
    output logic                      o_last_of_entry,
    output logic                      o_last_of_batch
);

    t_cmd w_cmd;
    t_sts w_sts;

    // controller
    bsfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    bsfe_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_occupancy      (i_occupancy),
        .i_pieces_low     (i_pieces_low),
        .i_pieces_high    (i_pieces_high),
        .i_white_to_move  (i_white_to_move),
        .i_score          (i_score),
        .i_game_result    (i_game_result),
        .o_entry_index    (o_entry_index),
        .o_feature_index  (o_feature_index),
        .o_feature_valid  (o_feature_valid),
        .o_feature_number (o_feature_number),
        .o_side_white     (o_side_white),
        .o_side_score     (o_side_score),
        .o_result_halves  (o_result_halves),
        .o_last_of_entry  (o_last_of_entry),
        .o_last_of_batch  (o_last_of_batch)
    );

endmodule

[sim/board_sparse_feature_extractor_checker.sv]
// ----------------------------------------------------------------------------
// board_sparse_feature_extractor_checker
// Watches both channels and the batch size register of the feature extractor,
// expands every accepted position record into its expected features and
// compares each output transfer against the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module board_sparse_feature_extractor_checker
    import bsfe_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [BATCH_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [SQ_W-1:0]           i_occupancy,
    input  logic [SQ_W-1:0]           i_pieces_low,
    input  logic [SQ_W-1:0]           i_pieces_high,
    input  logic                      i_white_to_move,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [RES_W-1:0]          i_game_result,
    // output channel
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [ENTRY_W-1:0]        i_entry_index,
    input  logic [FEAT_W-1:0]         i_feature_index,
    input  logic                      i_feature_valid,
    input  logic [FNUM_W-1:0]         i_feature_number,
    input  logic                      i_side_white,
    input  logic signed [SCORE_W-1:0] i_side_score,
    input  logic [RES_W-1:0]          i_result_halves,
    input  logic                      i_last_of_entry,
    input  logic                      i_last_of_batch,
    // status to the testbench
    output int                        o_pending,
    output int                        o_fail_count
);

    typedef struct {
        logic [ENTRY_W-1:0]        entry_index;
        logic [FEAT_W-1:0]         feature_index;
        logic                      feature_valid;
        logic [FNUM_W-1:0]         feature_number;
        logic                      side_white;
        logic signed [SCORE_W-1:0] side_score;
        logic [RES_W-1:0]          result_halves;
        logic                      last_of_entry;
        logic                      last_of_batch;
    } t_feature;

    // shadow of the block state
    logic [BATCH_W-1:0] batch_reg;
    logic [ENTRY_W-1:0] entry_cnt;
    logic [FNUM_W-1:0]  feat_cnt;
    t_feature           owed_features[$];
    int                 fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // expand one position record into the features it should produce
    task automatic expand_position(
        input logic [SQ_W-1:0]           occ,
        input logic [NIB_W-1:0]          nibs,
        input logic                      white,
        input logic signed [SCORE_W-1:0] score,
        input logic [RES_W-1:0]          res
    );
        logic [SQ_W-1:0]    squares;
        logic [NIB_W-1:0]   piece_list;
        logic [BATCH_W-1:0] eff_batch;
        logic [3:0]         nib;
        logic               closes;
        t_feature           f;

        // batch size of zero acts as one, oversize acts as the maximum
        if (batch_reg == '0) begin
            eff_batch = BATCH_W'(1);
        end else if (batch_reg > MAX_BATCH) begin
            eff_batch = MAX_BATCH;
        end else begin
            eff_batch = batch_reg;
        end
        closes = (int'(entry_cnt) + 1) >= int'(eff_batch);

        f.entry_index   = entry_cnt;
        f.side_white    = white;
        f.side_score    = score;
        f.result_halves = (res == RES_INVALID) ? RES_WIN : res;

        if (occ == '0) begin
            // empty board: one marker result, feature count holds
            f.feature_index  = '0;
            f.feature_valid  = 1'b0;
            f.feature_number = feat_cnt;
            f.last_of_entry  = 1'b1;
            f.last_of_batch  = closes;
            owed_features.insert(owed_features.size(), f);
        end else begin
            squares    = occ;
            piece_list = nibs;
            for (int sq = 0; sq < SQ_W; sq++) begin
                if (squares[sq]) begin
                    // next nibble; once the list runs dry zeros shift in
                    nib         = piece_list[3:0];
                    piece_list  = piece_list >> 4;
                    squares[sq] = 1'b0;
                    f.feature_index  = (nib[0] ? FEAT_W'(0) : BLACK_OFFSET)
                                     + FEAT_W'(nib[3:1]) * FEAT_W'(SQ_W) + FEAT_W'(sq);
                    f.feature_valid  = 1'b1;
                    f.feature_number = feat_cnt;
                    f.last_of_entry  = (squares == '0);
                    f.last_of_batch  = (squares == '0) && closes;
                    owed_features.insert(owed_features.size(), f);
                    feat_cnt = feat_cnt + 1'b1;
                end
            end
        end

        // counters restart after the last record of a batch
        if (closes) begin
            entry_cnt = '0;
            feat_cnt  = '0;
        end else begin
            entry_cnt = entry_cnt + 1'b1;
        end
    endtask

    task automatic check_field(
        input string               name,
        input logic signed [63:0]  want,
        input logic signed [63:0]  got
    );
        if (got !== want) begin
            fail_cnt++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // compare one output transfer with the oldest owed feature
    task automatic check_feature();
        t_feature f;

        if (owed_features.size() == 0) begin
            fail_cnt++;
            $error("unexpected transfer: entry_index %0d feature_index %0d",
                   i_entry_index, i_feature_index);
        end else begin
            f = owed_features.pop_front();
            check_field("entry_index",    f.entry_index,    i_entry_index);
            check_field("feature_index",  f.feature_index,  i_feature_index);
            check_field("feature_valid",  f.feature_valid,  i_feature_valid);
            check_field("feature_number", f.feature_number, i_feature_number);
            check_field("side_white",     f.side_white,     i_side_white);
            check_field("side_score",     f.side_score,     i_side_score);
            check_field("result_halves",  f.result_halves,  i_result_halves);
            check_field("last_of_entry",  f.last_of_entry,  i_last_of_entry);
            check_field("last_of_batch",  f.last_of_batch,  i_last_of_batch);
        end
    endtask

    // sample both channels on the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            batch_reg = BATCH_RESET;
            entry_cnt = '0;
            feat_cnt  = '0;
            owed_features.delete();
        end else begin
            if (i_cfg_we) begin
                batch_reg = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                expand_position(i_occupancy, {i_pieces_high, i_pieces_low},
                                i_white_to_move, i_score, i_game_result);
            end
            if (i_out_valid && i_out_ready) begin
                check_feature();
            end
        end
        o_pending <= owed_features.size();
    end

endmodule

[sim/tb_board_sparse_feature_extractor_top.sv]
// ----------------------------------------------------------------------------
// tb_board_sparse_feature_extractor_top
// Drives position records into the feature extractor under bursty input and a
// stalling output, across several batch sizes, and reports the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_board_sparse_feature_extractor_top;
    import bsfe_pkg::*;

    localparam int          CLK_HALF         = 5;
    localparam int          RESET_CYCLES     = 12;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          TAIL_CYCLES      = 80;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          LIGHT_ITEMS      = 16;
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;

    // result codes not named in the package
    localparam logic [RES_W-1:0] RES_LOSS = 2'd0;
    localparam logic [RES_W-1:0] RES_DRAW = 2'd1;

    typedef struct {
        logic [SQ_W-1:0]           occ;
        logic [SQ_W-1:0]           lo;
        logic [SQ_W-1:0]           hi;
        logic                      white;
        logic signed [SCORE_W-1:0] score;
        logic [RES_W-1:0]          res;
    } t_position;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [BATCH_W-1:0]        cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [SQ_W-1:0]           occupancy = '0;
    logic [SQ_W-1:0]           pieces_low = '0;
    logic [SQ_W-1:0]           pieces_high = '0;
    logic                      white_to_move = 1'b0;
    logic signed [SCORE_W-1:0] score = '0;
    logic [RES_W-1:0]          game_result = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [ENTRY_W-1:0]        entry_index;
    logic [FEAT_W-1:0]         feature_index;
    logic                      feature_valid;
    logic [FNUM_W-1:0]         feature_number;
    logic                      side_white;
    logic signed [SCORE_W-1:0] side_score;
    logic [RES_W-1:0]          result_halves;
    logic                      last_of_entry;
    logic                      last_of_batch;

    int                        pending;
    int                        fail_count;
    int unsigned               hold_req = 0;
    int unsigned               burst_left = 0;
    int unsigned               cycle_cnt = 0;

    always #CLK_HALF clk = ~clk;

    board_sparse_feature_extractor_top u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_occupancy      (occupancy),
        .i_pieces_low     (pieces_low),
        .i_pieces_high    (pieces_high),
        .i_white_to_move  (white_to_move),
        .i_score          (score),
        .i_game_result    (game_result),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_entry_index    (entry_index),
        .o_feature_index  (feature_index),
        .o_feature_valid  (feature_valid),
        .o_feature_number (feature_number),
        .o_side_white     (side_white),
        .o_side_score     (side_score),
        .o_result_halves  (result_halves),
        .o_last_of_entry  (last_of_entry),
        .o_last_of_batch  (last_of_batch)
    );

    board_sparse_feature_extractor_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_occupancy      (occupancy),
        .i_pieces_low     (pieces_low),
        .i_pieces_high    (pieces_high),
        .i_white_to_move  (white_to_move),
        .i_score          (score),
        .i_game_result    (game_result),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_entry_index    (entry_index),
        .i_feature_index  (feature_index),
        .i_feature_valid  (feature_valid),
        .i_feature_number (feature_number),
        .i_side_white     (side_white),
        .i_side_score     (side_score),
        .i_result_halves  (result_halves),
        .i_last_of_entry  (last_of_entry),
        .i_last_of_batch  (last_of_batch),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    function automatic t_position mk_position(
        input logic [SQ_W-1:0]           occ,
        input logic [SQ_W-1:0]           lo,
        input logic [SQ_W-1:0]           hi,
        input logic                      white,
        input logic signed [SCORE_W-1:0] sc,
        input logic [RES_W-1:0]          res
    );
        t_position p;
        p.occ   = occ;
        p.lo    = lo;
        p.hi    = hi;
        p.white = white;
        p.score = sc;
        p.res   = res;
        return p;
    endfunction

    function automatic logic [SQ_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // occupancy with up to n pieces on random squares
    function automatic logic [SQ_W-1:0] scatter_pieces(input int unsigned n);
        logic [SQ_W-1:0] occ;
        occ = '0;
        repeat (n) occ[$urandom_range(0, SQ_W - 1)] = 1'b1;
        return occ;
    endfunction

    // mostly game-like boards, some empty, full and overfull ones
    function automatic t_position random_position();
        t_position   p;
        int unsigned pick;
        p    = mk_position('0, rand64(), rand64(), 1'($urandom_range(0, 1)),
                           SCORE_W'($urandom()), RES_W'($urandom_range(0, 3)));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            p.occ = '0;
        end else if (pick < 10) begin
            p.occ = '1;
        end else if (pick < 20) begin
            p.occ = rand64() | rand64();
        end else if (pick < 30) begin
            p.occ = rand64();
        end else if (pick < 50) begin
            p.occ = scatter_pieces($urandom_range(1, 6));
        end else begin
            p.occ = scatter_pieces($urandom_range(2, 32));
        end
        if ($urandom_range(0, 9) == 0) begin
            p.score = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        return p;
    endfunction

    // short records: empty, one or two pieces
    function automatic t_position light_position();
        t_position p;
        p = random_position();
        case ($urandom_range(0, 4))
            0:       p.occ = '0;
            1:       p.occ = scatter_pieces(2);
            default: p.occ = scatter_pieces(1);
        endcase
        return p;
    endfunction

    // offer one record, hold it until the transfer, then maybe pause
    task automatic send_position(input t_position p);
        int unsigned gap;
        in_valid      <= 1'b1;
        occupancy     <= p.occ;
        pieces_low    <= p.lo;
        pieces_high   <= p.hi;
        white_to_move <= p.white;
        score         <= p.score;
        game_result   <= p.res;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop offering and wait until every owed feature has left
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_batch_len(input logic [BATCH_W-1:0] size);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        logic [BATCH_W-1:0] phase_sizes [8];
        logic [BATCH_W-1:0] size;

        phase_sizes = '{13'd1, 13'd4096, 13'd2, 13'd0, 13'd5, 13'd3, 13'd1, 13'd0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed records at the reset batch size
        // empty boards with score and result extremes
        send_position(mk_position('0, '0, '0, 1'b1, 16'sh7FFF, RES_LOSS));
        send_position(mk_position('0, '1, '1, 1'b0, 16'sh8000, RES_INVALID));
        // square zero and the highest feature index
        send_position(mk_position(64'h1, 64'hF, '0, 1'b0, 16'sh0000, RES_DRAW));
        send_position(mk_position(64'h8000_0000_0000_0000, 64'hE, '0, 1'b1, -16'sd1,
                                  RES_WIN));
        // every nibble value once, in both halves of the piece list
        send_position(mk_position(64'h0000_0000_0000_FFFF, 64'hFEDC_BA98_7654_3210, '0,
                                  1'b1, 16'sd100, RES_DRAW));
        send_position(mk_position(64'hFFFF_FFFF_0000_0000, 64'h0123_4567_89AB_CDEF,
                                  64'hFEDC_BA98_7654_3210, 1'b0, -16'sd100, RES_WIN));
        // exactly 32 pieces, then 33 where the last square gets an empty nibble
        send_position(mk_position(64'hF0F0_F0F0_F0F0_F0F0, '1, '1, 1'b1, 16'sd1,
                                  RES_LOSS));
        send_position(mk_position(64'h0000_0001_FFFF_FFFF, '1, '1, 1'b0, 16'sd2,
                                  RES_INVALID));
        // full boards
        send_position(mk_position('1, '1, '1, 1'b1, 16'sh7FFF, RES_WIN));
        send_position(mk_position('1, '0, '0, 1'b0, 16'sh8000, RES_LOSS));
        // alternating squares and nibbles
        send_position(mk_position(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                                  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 16'sh5555, RES_DRAW));
        send_position(mk_position(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                  64'h5555_5555_5555_5555, 1'b0, 16'shAAAA, RES_WIN));
        // two corner pieces, result code three saturates
        send_position(mk_position(64'h8000_0000_0000_0001, 64'h21, '0, 1'b1, 16'sd0,
                                  RES_INVALID));

        // batch size zero acts as one: every record closes its batch
        set_batch_len('0);
        repeat (8) send_position(random_position());

        // oversize setting acts as the maximum; short records under pressure
        set_batch_len(13'h1FFF);
        hold_req <= hold_req + 1;
        repeat (LIGHT_ITEMS) send_position(light_position());

        // random phases, sizes that do not align with the running counter
        for (int ph = 0; ph < 8; ph++) begin
            size = (phase_sizes[ph] == '0) ? BATCH_W'($urandom_range(4, 60))
                                           : phase_sizes[ph];
            set_batch_len(size);
            if (ph == 1 || ph == 5) begin
                hold_req <= hold_req + 1;
            end
            repeat ($urandom_range(24, 32)) send_position(random_position());
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // output ready: random stall modes plus a long hold on request
    initial begin
        t_rx_mode    rx_mode;
        int unsigned mode_left;
        int unsigned tick;
        int unsigned hold_seen;

        rx_mode   = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        hold_seen = 0;
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                tick++;
                case (rx_mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= (tick % 4 == 0);
                    default:   out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/bsfe_pkg.sv
rtl/bsfe_ctrl.sv
rtl/bsfe_datapath.sv
rtl/board_sparse_feature_extractor_top.sv
sim/board_sparse_feature_extractor_checker.sv
sim/tb_board_sparse_feature_extractor_top.sv
